// ===== rtl/refcounted_lru_buffer_pool_core_macros.svh =====
// ============================================================================
// refcounted lru buffer pool core - assertion macros
// Clocked assertion helpers, compiled out when NO_ASSERTIONS is set.
// ============================================================================
`ifndef REFCOUNTED_LRU_BUFFER_POOL_CORE_MACROS_SVH
`define REFCOUNTED_LRU_BUFFER_POOL_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked on every edge once reset is released
`define RLBP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every edge, reset included
`define RLBP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define RLBP_ASSERT(label, clk, rst, prop, msg)
`define RLBP_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== rtl/rlbp_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rlbp_pkg
// Shared constants, codes and inter-module structs of the buffer pool core.
// ============================================================================
package rlbp_pkg;

   // pool geometry
   localparam int NUM_BUFFERS = 16;
   localparam int IDX_W       = $clog2(NUM_BUFFERS);
   localparam int REF_BITS    = 8;

   // fixed field widths of the request and response beats
   localparam int OP_W     = 2;
   localparam int DRIVE_W  = 8;
   localparam int BLOCK_W  = 32;
   localparam int BI_W     = 4;
   localparam int STATUS_W = 2;
   localparam int RIDX_W   = 4;
   localparam int RCNT_W   = 8;

   typedef enum logic [OP_W-1:0] {
      OP_GET       = 2'd0,
      OP_RELEASE   = 2'd1,
      OP_FILL_FAIL = 2'd2,
      OP_UNUSED    = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE    = 2'd0,
      ST_FILL    = 2'd1,
      ST_NO_BUF  = 2'd2,
      ST_CNT_ERR = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_GET_END,
      S_REL,
      S_POS_SCAN,
      S_FAIL,
      S_NOP
   } state_type;

   // flags from the shared compare unit
   typedef struct packed {
      logic                tag_hit;
      logic                cnt_zero;
      logic                cnt_one;
      logic                cnt_max;
      logic                order_hit;
      logic [REF_BITS-1:0] cnt_inc;
      logic [REF_BITS-1:0] cnt_dec;
   } cmp_res_type;

   // sequencer controls to the datapath
   typedef struct packed {
      logic             busy;
      logic             scan_last;
      logic [IDX_W-1:0] scan_ptr;
      logic             in_scan;
      logic             in_get_end;
      logic             in_rel;
      logic             in_pos_scan;
      logic             in_fail;
      logic             in_nop;
   } seq_ctrl_type;

endpackage

// ===== rtl/rlbp_cmp_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rlbp_cmp_unit
// Shared compare and count arithmetic, applied to one pool entry per cycle.
// ============================================================================
module rlbp_cmp_unit
   import rlbp_pkg::*;
(
   input  logic                entry_valid,
   input  logic [DRIVE_W-1:0]  entry_drive,
   input  logic [BLOCK_W-1:0]  entry_block,
   input  logic [REF_BITS-1:0] entry_count,
   input  logic [IDX_W-1:0]    order_val,
   input  logic [IDX_W-1:0]    cur_idx,
   input  logic [DRIVE_W-1:0]  want_drive,
   input  logic [BLOCK_W-1:0]  want_block,
   output cmp_res_type         res
);

   // tag compare, count tests and the count incrementer and decrementer
   always_comb begin
      res.tag_hit   = entry_valid && (entry_drive == want_drive) && (entry_block == want_block);
      res.cnt_zero  = (entry_count == '0);
      res.cnt_one   = (entry_count == REF_BITS'(1));
      res.cnt_max   = &entry_count;
      res.order_hit = (order_val == cur_idx);
      res.cnt_inc   = entry_count + REF_BITS'(1);
      res.cnt_dec   = entry_count - REF_BITS'(1);
   end

endmodule

// ===== rtl/rlbp_seq.sv =====
`timescale 1ns / 1ps
// ============================================================================
// rlbp_seq
// Sequencer: walks the recency list one position a cycle for gets and for releases that free an entry.
// ============================================================================
module rlbp_seq
   import rlbp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  opcode_type   opcode,
   input  logic         range_err,
   input  cmp_res_type  cmp,
   output seq_ctrl_type ctrl
);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic             last;

   assign last = (ptr_ff == IDX_W'(NUM_BUFFERS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (opcode)
                  OP_GET:       state_in = S_SCAN;
                  OP_RELEASE:   state_in = S_REL;
                  OP_FILL_FAIL: state_in = S_FAIL;
                  default:      state_in = S_NOP;
               endcase
            end
         end
         S_SCAN: begin
            if (cmp.tag_hit || last) state_in = S_GET_END;
         end
         S_GET_END: state_in = S_IDLE;
         S_REL: begin
            if (!range_err && !cmp.cnt_zero && cmp.cnt_one) state_in = S_POS_SCAN;
            else state_in = S_IDLE;
         end
         S_POS_SCAN: begin
            if (cmp.order_hit || last) state_in = S_IDLE;
         end
         S_FAIL:  state_in = S_IDLE;
         S_NOP:   state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // list position pointer
   always_comb begin
      ptr_in = ptr_ff;
      if (state_ff == S_IDLE) ptr_in = '0;
      else if ((state_ff == S_SCAN || state_ff == S_POS_SCAN) && !last) ptr_in = ptr_ff + IDX_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ptr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
      end
   end

   // outputs
   always_comb begin
      ctrl.busy        = (state_ff != S_IDLE);
      ctrl.scan_last   = last;
      ctrl.scan_ptr    = ptr_ff;
      ctrl.in_scan     = 1'b0;
      ctrl.in_get_end  = 1'b0;
      ctrl.in_rel      = 1'b0;
      ctrl.in_pos_scan = 1'b0;
      ctrl.in_fail     = 1'b0;
      ctrl.in_nop      = 1'b0;
      unique case (state_ff)
         S_IDLE:     ;
         S_SCAN:     ctrl.in_scan     = 1'b1;
         S_GET_END:  ctrl.in_get_end  = 1'b1;
         S_REL:      ctrl.in_rel      = 1'b1;
         S_POS_SCAN: ctrl.in_pos_scan = 1'b1;
         S_FAIL:     ctrl.in_fail     = 1'b1;
         S_NOP:      ctrl.in_nop      = 1'b1;
         default:    ;
      endcase
   end

endmodule

// ===== rtl/refcounted_lru_buffer_pool_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// refcounted_lru_buffer_pool_core
// Tag and reference-count manager for a pool of sixteen block buffers.
// ============================================================================
// Usage:
//   A request beat (req_opcode, req_drive_id, req_block_number, req_buf_index)
//   is taken at a rising edge with start high and busy low. busy stays high
//   while the request is worked on; start is ignored meanwhile.
//   Exactly one response beat follows each request: rsp_valid is high for one
//   cycle with rsp_status, rsp_result_index and rsp_ref_count_after, and the
//   receiver takes it at the edge that ends that cycle; there is no stall.
//   Get walks the recency list one position per cycle through a single
//   compare unit, stopping on a tag hit; a miss walks the whole list.
//   Release answers without a walk; when the count drops to zero it
//   walks the list instead to find the entry's position, shifts the list
//   towards the head at the edge that finds it and answers from that step.
//   Fill failed and the unused opcode answer without a walk.
//   busy falls in the cycle the response is shown, so the next request may be
//   taken in that same cycle.
//   Reset (synchronous, active high) clears valid bits and counts and puts
//   entry p at list position p; tags stay undefined until a get claims one.
// ============================================================================
`include "refcounted_lru_buffer_pool_core_macros.svh"

module refcounted_lru_buffer_pool_core
   import rlbp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [OP_W-1:0]     req_opcode,
   input  logic [DRIVE_W-1:0]  req_drive_id,
   input  logic [BLOCK_W-1:0]  req_block_number,
   input  logic [BI_W-1:0]     req_buf_index,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [RIDX_W-1:0]   rsp_result_index,
   output logic [RCNT_W-1:0]   rsp_ref_count_after
);

   seq_ctrl_type ctrl;
   cmp_res_type  cmp;
   logic         accept;

   // pool state
   logic [DRIVE_W-1:0]  tag_drive_ff [NUM_BUFFERS];
   logic [BLOCK_W-1:0]  tag_block_ff [NUM_BUFFERS];
   logic [NUM_BUFFERS-1:0] valid_ff;
   logic [REF_BITS-1:0] count_ff [NUM_BUFFERS];
   logic [IDX_W-1:0]    order_ff [NUM_BUFFERS];

   // request and scan context
   logic [DRIVE_W-1:0] drive_ff;
   logic [BLOCK_W-1:0] block_ff;
   logic [BI_W-1:0]    bi_ff;
   logic [IDX_W-1:0]   cur_ff, cur_in;
   logic               range_err_ff;
   logic               hit_found_ff, hit_found_in;
   logic               free_found_ff, free_found_in;

   // response beat
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [RIDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [RCNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;

   logic [IDX_W-1:0] sel_idx;
   logic [IDX_W-1:0] ord_val;
   logic             shift_en;
   logic             cnt_we;
   logic [REF_BITS-1:0] cnt_wdata;
   logic             claim_we;
   logic             fail_we;
   logic [NUM_BUFFERS-1:0] cnt_nz;

   assign busy   = ctrl.busy;
   assign accept = start && !ctrl.busy;

   rlbp_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .opcode    (opcode_type'(req_opcode)),
      .range_err (range_err_ff),
      .cmp       (cmp),
      .ctrl      (ctrl)
   );

   // entry under the compare unit: list walk during a get, else the held entry
   assign ord_val = order_ff[ctrl.scan_ptr];
   assign sel_idx = ctrl.in_scan ? ord_val : cur_ff;

   rlbp_cmp_unit u_cmp (
      .entry_valid (valid_ff[sel_idx]),
      .entry_drive (tag_drive_ff[sel_idx]),
      .entry_block (tag_block_ff[sel_idx]),
      .entry_count (count_ff[sel_idx]),
      .order_val   (ord_val),
      .cur_idx     (cur_ff),
      .want_drive  (drive_ff),
      .want_block  (block_ff),
      .res         (cmp)
   );

   // scan bookkeeping, updates and response
   always_comb begin
      cur_in        = cur_ff;
      hit_found_in  = hit_found_ff;
      free_found_in = free_found_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_DONE;
      rsp_idx_in    = '0;
      rsp_cnt_in    = '0;
      shift_en      = 1'b0;
      cnt_we        = 1'b0;
      cnt_wdata     = '0;
      claim_we      = 1'b0;
      fail_we       = 1'b0;

      if (accept) begin
         cur_in        = IDX_W'(req_buf_index);
         hit_found_in  = 1'b0;
         free_found_in = 1'b0;
      end

      // get: first tag hit wins, first free entry is kept as fallback
      if (ctrl.in_scan) begin
         if (cmp.tag_hit) begin
            hit_found_in = 1'b1;
            cur_in       = sel_idx;
         end else if (cmp.cnt_zero && !free_found_ff) begin
            free_found_in = 1'b1;
            cur_in        = sel_idx;
         end
      end

      if (ctrl.in_get_end) begin
         rsp_valid_in = 1'b1;
         if (hit_found_ff) begin
            rsp_idx_in = RIDX_W'(cur_ff);
            if (cmp.cnt_max) begin
               rsp_status_in = ST_CNT_ERR;
               rsp_cnt_in    = RCNT_W'(count_ff[cur_ff]);
            end else begin
               cnt_we     = 1'b1;
               cnt_wdata  = cmp.cnt_inc;
               rsp_cnt_in = RCNT_W'(cmp.cnt_inc);
            end
         end else if (free_found_ff) begin
            claim_we      = 1'b1;
            cnt_we        = 1'b1;
            cnt_wdata     = REF_BITS'(1);
            rsp_status_in = ST_FILL;
            rsp_idx_in    = RIDX_W'(cur_ff);
            rsp_cnt_in    = RCNT_W'(1);
         end else begin
            rsp_status_in = ST_NO_BUF;
         end
      end

      // release: decrement, and walk for the list place when it hits zero
      if (ctrl.in_rel) begin
         rsp_idx_in = RIDX_W'(bi_ff);
         if (range_err_ff || cmp.cnt_zero) begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_CNT_ERR;
         end else begin
            cnt_we    = 1'b1;
            cnt_wdata = cmp.cnt_dec;
            if (!cmp.cnt_one) begin
               rsp_valid_in = 1'b1;
               rsp_cnt_in   = RCNT_W'(cmp.cnt_dec);
            end
         end
      end

      if (ctrl.in_pos_scan && (cmp.order_hit || ctrl.scan_last)) begin
         shift_en     = cmp.order_hit;
         rsp_valid_in = 1'b1;
         rsp_idx_in   = RIDX_W'(bi_ff);
      end

      // fill failed: free and invalidate
      if (ctrl.in_fail) begin
         rsp_valid_in = 1'b1;
         rsp_idx_in   = RIDX_W'(bi_ff);
         if (range_err_ff) rsp_status_in = ST_CNT_ERR;
         else fail_we = 1'b1;
      end

      if (ctrl.in_nop) rsp_valid_in = 1'b1;
   end

   // request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         drive_ff     <= req_drive_id;
         block_ff     <= req_block_number;
         bi_ff        <= req_buf_index;
         range_err_ff <= ({1'b0, req_buf_index} >= (BI_W + 1)'(NUM_BUFFERS));
      end
      cur_ff <= cur_in;
   end

   // tags, written only on a claim
   always_ff @(posedge clock) begin
      if (claim_we) begin
         tag_drive_ff[cur_ff] <= drive_ff;
         tag_block_ff[cur_ff] <= block_ff;
      end
   end

   // valid bits, counts, recency list and control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < NUM_BUFFERS; i++) begin
            count_ff[i] <= '0;
            order_ff[i] <= IDX_W'(i);
         end
      end else begin
         hit_found_ff  <= hit_found_in;
         free_found_ff <= free_found_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (cnt_we) count_ff[cur_ff] <= cnt_wdata;
         if (claim_we) valid_ff[cur_ff] <= 1'b1;
         if (fail_we) begin
            count_ff[cur_ff] <= '0;
            valid_ff[cur_ff] <= 1'b0;
         end
         // move to tail: positions from the hit onwards take their successor
         if (shift_en) begin
            for (int p = 0; p < NUM_BUFFERS - 1; p++) begin
               if (IDX_W'(p) >= ctrl.scan_ptr) order_ff[p] <= order_ff[p + 1];
            end
            order_ff[NUM_BUFFERS - 1] <= cur_ff;
         end
      end
   end

   // response beat registers
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_result_index    = rsp_idx_ff;
   assign rsp_ref_count_after = rsp_cnt_ff;

   // entries holding references
   always_comb begin
      for (int i = 0; i < NUM_BUFFERS; i++) cnt_nz[i] = |count_ff[i];
   end

   // checks
   `RLBP_ASSERT(a_accept_busy, clock, reset, accept |=> busy, "accepted request did not raise busy")
   `RLBP_ASSERT(a_rsp_after_busy, clock, reset, rsp_valid |-> $past(busy), "response beat without a request in progress")
   `RLBP_ASSERT(a_rsp_single, clock, reset, rsp_valid |=> !rsp_valid, "two response beats in a row")
   `RLBP_ASSERT(a_ref_implies_valid, clock, reset, (cnt_nz & ~valid_ff) == '0, "referenced entry is not valid")

endmodule

// ===== dv/refcounted_lru_buffer_pool_core_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// refcounted_lru_buffer_pool_core_tb
// Self-checking bench for the buffer pool core. A behavioural model of the
// tags, counts and recency list predicts each response beat. Requests come
// from a backlog built at time zero: a directed opening, then mixed sessions
// of gets and releases, pool exhaustion, count saturation and random noise.
// Requests go out in bursts with random gaps between them.
// ============================================================================
module refcounted_lru_buffer_pool_core_tb;
   import rlbp_pkg::*;

   localparam logic [REF_BITS-1:0] CNT_TOP = '1;
   localparam int NUM_TAGS = 6;
   localparam int NUM_ITEMS = 1950;

   typedef struct {
      opcode_type          op;
      logic [DRIVE_W-1:0]  drv;
      logic [BLOCK_W-1:0]  blk;
      logic [BI_W-1:0]     bi;
   } pool_req_type;

   typedef struct {
      status_type          st;
      logic [RIDX_W-1:0]   idx;
      logic [RCNT_W-1:0]   cnt;
   } pool_rsp_type;

   // dut ports
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [OP_W-1:0]     req_opcode = '0;
   logic [DRIVE_W-1:0]  req_drive_id = '0;
   logic [BLOCK_W-1:0]  req_block_number = '0;
   logic [BI_W-1:0]     req_buf_index = '0;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [RIDX_W-1:0]   rsp_result_index;
   logic [RCNT_W-1:0]   rsp_ref_count_after;

   // model of the pool state
   logic [DRIVE_W-1:0]  buf_drv   [NUM_BUFFERS];
   logic [BLOCK_W-1:0]  buf_blk   [NUM_BUFFERS];
   logic                buf_valid [NUM_BUFFERS];
   logic [REF_BITS-1:0] buf_cnt   [NUM_BUFFERS];
   logic [IDX_W-1:0]    lru_order [NUM_BUFFERS];

   pool_req_type req_backlog_q[$];
   pool_rsp_type rsp_due_q[$];
   pool_req_type cur_req;
   pool_rsp_type exp_rsp;
   int           mismatch_cnt = 0;
   int           burst_left = 0;
   int           gap_left = 0;
   int           total_items = 0;
   int           rsp_seen = 0;

   refcounted_lru_buffer_pool_core uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_drive_id       (req_drive_id),
      .req_block_number   (req_block_number),
      .req_buf_index      (req_buf_index),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_result_index   (rsp_result_index),
      .rsp_ref_count_after(rsp_ref_count_after)
   );

   always #5 clock = ~clock;

   function automatic pool_rsp_type rsp_of(status_type s, int idx, int cnt);
      pool_rsp_type rs;
      rs.st  = s;
      rs.idx = idx[RIDX_W-1:0];
      rs.cnt = cnt[RCNT_W-1:0];
      return rs;
   endfunction

   task automatic pool_clear();
      int i;
      for (i = 0; i < NUM_BUFFERS; i++) begin
         buf_drv[i]   = '0;
         buf_blk[i]   = '0;
         buf_valid[i] = 1'b0;
         buf_cnt[i]   = '0;
         lru_order[i] = i[IDX_W-1:0];
      end
   endtask

   // apply one request to the pool model and work out its response beat
   task automatic pool_apply(input pool_req_type rq, output pool_rsp_type rs);
      int  p;
      int  e;
      int  pos;
      bit  found;
      rs = rsp_of(ST_DONE, 0, 0);
      found = 1'b0;
      case (rq.op)
         OP_GET: begin
            // tag lookup among valid entries, head to tail
            for (p = 0; p < NUM_BUFFERS && !found; p++) begin
               e = lru_order[p];
               if (buf_valid[e] && buf_drv[e] == rq.drv && buf_blk[e] == rq.blk) begin
                  found = 1'b1;
                  if (buf_cnt[e] == CNT_TOP) begin
                     rs = rsp_of(ST_CNT_ERR, e, int'(buf_cnt[e]));
                  end else begin
                     buf_cnt[e] = buf_cnt[e] + 1'b1;
                     rs = rsp_of(ST_DONE, e, int'(buf_cnt[e]));
                  end
               end
            end
            // miss: claim the unreferenced entry nearest the head
            for (p = 0; p < NUM_BUFFERS && !found; p++) begin
               e = lru_order[p];
               if (buf_cnt[e] == '0) begin
                  found        = 1'b1;
                  buf_cnt[e]   = REF_BITS'(1);
                  buf_drv[e]   = rq.drv;
                  buf_blk[e]   = rq.blk;
                  buf_valid[e] = 1'b1;
                  rs = rsp_of(ST_FILL, e, 1);
               end
            end
            if (!found)
               rs = rsp_of(ST_NO_BUF, 0, 0);
         end
         OP_RELEASE, OP_FILL_FAIL: begin
            e = rq.bi;
            if (e >= NUM_BUFFERS) begin
               rs = rsp_of(ST_CNT_ERR, e, 0);
            end else if (rq.op == OP_FILL_FAIL) begin
               // frees and invalidates, list place kept
               buf_cnt[e]   = '0;
               buf_valid[e] = 1'b0;
               rs = rsp_of(ST_DONE, e, 0);
            end else if (buf_cnt[e] == '0) begin
               rs = rsp_of(ST_CNT_ERR, e, 0);
            end else begin
               buf_cnt[e] = buf_cnt[e] - 1'b1;
               // last reference gone: move entry to the tail
               if (buf_cnt[e] == '0) begin
                  pos = 0;
                  while (lru_order[pos] != e)
                     pos++;
                  for (p = pos; p < NUM_BUFFERS - 1; p++)
                     lru_order[p] = lru_order[p + 1];
                  lru_order[NUM_BUFFERS - 1] = e[IDX_W-1:0];
               end
               rs = rsp_of(ST_DONE, e, int'(buf_cnt[e]));
            end
         end
         default: ;
      endcase
   endtask

   // add a request to the backlog, tracking the pool so sequences can aim
   task automatic queue_req(input opcode_type op, input logic [DRIVE_W-1:0] d,
                            input logic [BLOCK_W-1:0] b, input logic [BI_W-1:0] bi,
                            output pool_rsp_type rs);
      pool_req_type rq;
      rq.op  = op;
      rq.drv = d;
      rq.blk = b;
      rq.bi  = bi;
      req_backlog_q.push_back(rq);
      pool_apply(rq, rs);
      rsp_due_q.push_back(rs);
   endtask

   // stimulus build and reset
   initial begin : stim
      logic [DRIVE_W-1:0] tag_drv [NUM_TAGS];
      logic [BLOCK_W-1:0] tag_blk [NUM_TAGS];
      int                 held[$];
      pool_rsp_type       r;
      int                 k, j, kind, t;

      pool_clear();

      // hot tags: the first pairs share a block number on different drives, the last tag is all ones
      for (k = 0; k < NUM_TAGS; k++) begin
         tag_drv[k] = DRIVE_W'(k & 1);
         tag_blk[k] = BLOCK_W'(32'h1000 + (k >> 1));
      end
      tag_drv[NUM_TAGS - 1] = '1;
      tag_blk[NUM_TAGS - 1] = '1;

      // directed opening: unused opcode, underflow, fill failed on a free entry
      queue_req(OP_UNUSED, 8'h5a, 32'hdead_beef, BI_W'(7), r);
      queue_req(OP_RELEASE, '0, '0, BI_W'(5), r);
      queue_req(OP_FILL_FAIL, '0, '0, BI_W'(3), r);

      // one tag driven past the top of its count, then dropped by fill failed
      for (k = 0; k < int'(CNT_TOP) + 3; k++)
         queue_req(OP_GET, tag_drv[0], tag_blk[0], '0, r);
      queue_req(OP_FILL_FAIL, '0, '0, BI_W'(r.idx), r);

      // hit on a valid entry whose count has dropped to zero
      queue_req(OP_GET, tag_drv[1], tag_blk[1], '0, r);
      queue_req(OP_RELEASE, '0, '0, BI_W'(r.idx), r);
      queue_req(OP_GET, tag_drv[1], tag_blk[1], '0, r);
      queue_req(OP_RELEASE, '0, '0, BI_W'(r.idx), r);

      // fill the whole pool, one more get finds nothing free, then drain
      for (k = 0; k < NUM_BUFFERS; k++) begin
         queue_req(OP_GET, DRIVE_W'(8'h80 + k), BLOCK_W'($urandom), '0, r);
         held.push_back(int'(r.idx));
      end
      queue_req(OP_GET, tag_drv[2], tag_blk[2], '0, r);
      held.shuffle();
      for (k = 0; k < held.size(); k++)
         queue_req(OP_RELEASE, DRIVE_W'($urandom), BLOCK_W'($urandom), BI_W'(held[k]), r);
      held.delete();

      // random sessions of gets, releases, failed fills and noise
      while (req_backlog_q.size() < NUM_ITEMS) begin
         kind = $urandom_range(0, 99);
         if (kind < 8) begin
            queue_req(OP_GET, DRIVE_W'($urandom), BLOCK_W'($urandom), BI_W'($urandom), r);
            if (r.st == ST_DONE || r.st == ST_FILL) held.push_back(int'(r.idx));
         end else if (kind < 42) begin
            t = $urandom_range(0, NUM_TAGS - 1);
            queue_req(OP_GET, tag_drv[t], tag_blk[t], BI_W'($urandom), r);
            if (r.st == ST_DONE || r.st == ST_FILL) held.push_back(int'(r.idx));
         end else if (kind < 80 && held.size() > 0) begin
            j = $urandom_range(0, held.size() - 1);
            queue_req(OP_RELEASE, DRIVE_W'($urandom), BLOCK_W'($urandom),
                      BI_W'(held[j]), r);
            held.delete(j);
         end else if (kind < 88) begin
            queue_req(OP_RELEASE, DRIVE_W'($urandom), BLOCK_W'($urandom),
                      BI_W'($urandom), r);
         end else if (kind < 95) begin
            queue_req(OP_FILL_FAIL, DRIVE_W'($urandom), BLOCK_W'($urandom),
                      BI_W'($urandom), r);
         end else begin
            queue_req(OP_UNUSED, DRIVE_W'($urandom), BLOCK_W'($urandom),
                      BI_W'($urandom), r);
         end
      end

      total_items = req_backlog_q.size();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // driver: bursts of requests with random gaps, held until taken
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (req_backlog_q.size() > 0) begin
            cur_req = req_backlog_q.pop_front();
            start            <= 1'b1;
            req_opcode       <= cur_req.op;
            req_drive_id     <= cur_req.drv;
            req_block_number <= cur_req.blk;
            req_buf_index    <= cur_req.bi;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 12);
               gap_left   = $urandom_range(1, 40);
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: compare each response beat against the prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (rsp_due_q.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
               $display("unexpected response beat: st=%0d idx=%0d cnt=%0d",
                        rsp_status, rsp_result_index, rsp_ref_count_after);
         end else begin
            exp_rsp = rsp_due_q.pop_front();
            if (rsp_status !== exp_rsp.st || rsp_result_index !== exp_rsp.idx ||
                rsp_ref_count_after !== exp_rsp.cnt) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("mismatch on beat %0d: exp st=%0d idx=%0d cnt=%0d, got st=%0d idx=%0d cnt=%0d",
                           rsp_seen, exp_rsp.st, exp_rsp.idx, exp_rsp.cnt,
                           rsp_status, rsp_result_index, rsp_ref_count_after);
            end
            rsp_seen++;
            if (rsp_seen == total_items) begin
               if (mismatch_cnt == 0) $display("RESULT: OK");
               else $display("RESULT: ERROR");
               $finish;
            end
         end
      end
   end

   // run limit
   initial begin : limit
      #10_000_000;
      $display("run limit reached with %0d of %0d response beats", rsp_seen, total_items);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
